>>> rtl/core/tsol_pkg.sv
`default_nettype none

package tsol_pkg;

  localparam int unsigned KeyWidth = 32;
  localparam int unsigned CmdWidth = 2;
  localparam int unsigned StatusWidth = 2;
  localparam int unsigned EntryCountWidth = 5;

  localparam logic [CmdWidth-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdWidth-1:0] CMD_DELETE = 2'd1;
  localparam logic [CmdWidth-1:0] CMD_SEARCH = 2'd2;

  localparam logic [StatusWidth-1:0] ST_DONE    = 2'd0;
  localparam logic [StatusWidth-1:0] ST_PRESENT = 2'd1;
  localparam logic [StatusWidth-1:0] ST_ABSENT  = 2'd2;
  localparam logic [StatusWidth-1:0] ST_FULL    = 2'd3;

  // Update applied by every cell in the same cycle
  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE,
    OP_SWAP
  } op_e;

  typedef struct packed {
    logic                cmp;
    op_e                 op;
    logic [KeyWidth-1:0] key;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/tsol_cell.sv
`default_nettype none

module tsol_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  wire logic                               clk_i,
  input  wire tsol_pkg::cell_ctl_t                ctl_i,
  input  wire logic [CW-1:0]                      count_i,
  input  wire logic [tsol_pkg::KeyWidth-1:0]      left_entry_i,
  input  wire logic [tsol_pkg::KeyWidth-1:0]      right_entry_i,
  input  wire logic                               right_hit_i,
  input  wire logic                               seen_i,
  output logic                                    seen_o,
  output logic                                    hit_o,
  output logic [tsol_pkg::KeyWidth-1:0]           entry_o
);

  localparam logic [CW-1:0] IdxC = CW'(IDX);

  logic [tsol_pkg::KeyWidth-1:0] entry_q, entry_d;
  logic                          hit_q, hit_d;
  logic                          valid;

  assign valid  = count_i > IdxC;
  assign seen_o = seen_i | hit_q;
  assign hit_o  = hit_q;
  assign entry_o = entry_q;

  always_comb begin
    hit_d = hit_q;
    if (ctl_i.cmp) begin
      hit_d = valid && (entry_q == ctl_i.key);
    end
  end

  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.op)
      tsol_pkg::OP_INSERT: begin
        if (count_i == IdxC) entry_d = ctl_i.key;
      end
      tsol_pkg::OP_DELETE: begin
        // close the gap from the hit position toward the tail
        if (seen_o) entry_d = right_entry_i;
      end
      tsol_pkg::OP_SWAP: begin
        if (right_hit_i) begin
          entry_d = right_entry_i;
        end else if (hit_q && (IDX != 0)) begin
          entry_d = left_entry_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    hit_q   <= hit_d;
  end

endmodule

`default_nettype wire

>>> rtl/core/transpose_self_organizing_list.sv
// A result word is registered out as the update state ends, marked by done_o for
// exactly one cycle, and is taken in that cycle.
// A new command is taken only in the idle state: each passes a compare state, then an
// update state across the row of cells; busy is high in both and low again in idle.
// Reset (rst_ni low, asynchronous) empties the list; stored keys are not cleared.
// The receiver cannot stall: each result is taken in the cycle it is shown.
`default_nettype none

module transpose_self_organizing_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       start,
  output logic                                            busy,
  input  wire logic [tsol_pkg::CmdWidth-1:0]              command_i,
  input  wire logic signed [tsol_pkg::KeyWidth-1:0]       key_i,
  output logic                                            done_o,
  output logic [tsol_pkg::StatusWidth-1:0]                status_o,
  output logic [tsol_pkg::EntryCountWidth-1:0]            entry_count_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  state_e                                 state_q, state_d;
  logic                                   busy_q, busy_d;
  logic                                   done_q, done_d;
  logic [tsol_pkg::StatusWidth-1:0]       status_q, status_d;
  logic [tsol_pkg::EntryCountWidth-1:0]   entry_count_q, entry_count_d;
  logic [CW-1:0]                          count_q, count_d;
  logic [tsol_pkg::CmdWidth-1:0]          cmd_q;
  logic [tsol_pkg::KeyWidth-1:0]          key_q;

  tsol_pkg::cell_ctl_t                    ctl;
  tsol_pkg::op_e                          op;
  logic [tsol_pkg::StatusWidth-1:0]       status_c;
  logic [CW+tsol_pkg::EntryCountWidth-1:0] count_wide;

  logic [tsol_pkg::KeyWidth-1:0] ent  [CAPACITY];
  logic                          hit  [CAPACITY];
  logic                          seen [CAPACITY+1];
  logic                          any_hit;
  logic                          full;

  assign seen[0] = 1'b0;
  assign any_hit = seen[CAPACITY];
  assign full    = (count_q == CapC);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [tsol_pkg::KeyWidth-1:0] left_entry, right_entry;
    logic                          right_hit;

    if (i == 0) begin : g_head
      assign left_entry = ent[i];
    end else begin : g_mid_l
      assign left_entry = ent[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = ent[i];
      assign right_hit   = 1'b0;
    end else begin : g_mid_r
      assign right_entry = ent[i+1];
      assign right_hit   = hit[i+1];
    end

    tsol_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .count_i       (count_q),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .right_hit_i   (right_hit),
      .seen_i        (seen[i]),
      .seen_o        (seen[i+1]),
      .hit_o         (hit[i]),
      .entry_o       (ent[i])
    );
  end

  // Pick the update and the status from the registered compare hits
  always_comb begin
    op       = tsol_pkg::OP_NONE;
    status_c = tsol_pkg::ST_ABSENT;
    unique case (cmd_q)
      tsol_pkg::CMD_INSERT: begin
        if (any_hit) begin
          status_c = tsol_pkg::ST_PRESENT;
        end else if (full) begin
          status_c = tsol_pkg::ST_FULL;
        end else begin
          status_c = tsol_pkg::ST_DONE;
          op       = tsol_pkg::OP_INSERT;
        end
      end
      tsol_pkg::CMD_DELETE: begin
        if (any_hit) begin
          status_c = tsol_pkg::ST_DONE;
          op       = tsol_pkg::OP_DELETE;
        end
      end
      tsol_pkg::CMD_SEARCH: begin
        if (any_hit) begin
          status_c = tsol_pkg::ST_DONE;
          op       = tsol_pkg::OP_SWAP;
        end
      end
      default: begin
        op       = tsol_pkg::OP_NONE;
        status_c = tsol_pkg::ST_ABSENT;
      end
    endcase
  end

  always_comb begin
    ctl.cmp = (state_q == S_CMP);
    ctl.op  = (state_q == S_UPD) ? op : tsol_pkg::OP_NONE;
    ctl.key = key_q;
  end

  always_comb begin
    count_d = count_q;
    if (state_q == S_UPD) begin
      if (op == tsol_pkg::OP_INSERT) begin
        count_d = count_q + CW'(1);
      end else if (op == tsol_pkg::OP_DELETE) begin
        count_d = count_q - CW'(1);
      end
    end
  end

  assign count_wide = (CW + tsol_pkg::EntryCountWidth)'(count_d);

  always_comb begin
    state_d       = state_q;
    busy_d        = busy_q;
    done_d        = 1'b0;
    status_d      = status_q;
    entry_count_d = entry_count_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_CMP;
          busy_d  = 1'b1;
        end
      end
      S_CMP: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        state_d       = S_IDLE;
        busy_d        = 1'b0;
        done_d        = 1'b1;
        status_d      = status_c;
        entry_count_d = count_wide[tsol_pkg::EntryCountWidth-1:0];
      end
      default: begin
        state_d = S_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      busy_q        <= 1'b0;
      done_q        <= 1'b0;
      status_q      <= tsol_pkg::ST_DONE;
      entry_count_q <= '0;
      count_q       <= '0;
    end else begin
      state_q       <= state_d;
      busy_q        <= busy_d;
      done_q        <= done_d;
      status_q      <= status_d;
      entry_count_q <= entry_count_d;
      count_q       <= count_d;
    end
  end

  // Hold the command word for the compare and update cycles
  always_ff @(posedge clk_i) begin
    if (start && !busy_q) begin
      cmd_q <= command_i;
      key_q <= key_i;
    end
  end

  assign busy          = busy_q;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign entry_count_o = entry_count_q;

endmodule

`default_nettype wire

>>> rtl/core/tsol_checker.sv
`default_nettype none

module tsol_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input wire logic                                      clk_i,
  input wire logic                                      rst_ni,
  input wire logic                                      start,
  input wire logic                                      busy,
  input wire logic [tsol_pkg::CmdWidth-1:0]             command_i,
  input wire logic signed [tsol_pkg::KeyWidth-1:0]      key_i,
  input wire logic                                      done_o,
  input wire logic [tsol_pkg::StatusWidth-1:0]          status_o,
  input wire logic [tsol_pkg::EntryCountWidth-1:0]      entry_count_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW+tsol_pkg::EntryCountWidth-1:0] CapW =
    (CW + tsol_pkg::EntryCountWidth)'(CAPACITY);

  logic accept;
  assign accept = start && !busy;

  // every accepted word is answered by a result strobe after the compare and update states
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 done_o)
    else $error("result word missing after accepted command");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy ##1 busy)
    else $error("busy not held through compare and update");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy ##1 !done_o)
    else $error("result strobe repeated or shown while busy");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == tsol_pkg::ST_FULL)) |->
      (entry_count_o == CapW[tsol_pkg::EntryCountWidth-1:0]))
    else $error("full status with count below capacity");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy, 1) && $past(busy, 2))
    else $error("result word without a command in flight");

endmodule

bind transpose_self_organizing_list tsol_checker #(.CAPACITY(CAPACITY)) u_tsol_checker (.*);

`default_nettype wire

>>> tb/list_checker.sv
`timescale 1ns / 100ps

module list_checker #(
  parameter int unsigned Capacity = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  input  wire logic                                  busy_i,
  input  wire logic [tsol_pkg::CmdWidth-1:0]         command_i,
  input  wire logic [tsol_pkg::KeyWidth-1:0]         key_i,
  input  wire logic                                  done_i,
  input  wire logic [tsol_pkg::StatusWidth-1:0]      status_i,
  input  wire logic [tsol_pkg::EntryCountWidth-1:0]  entry_count_i,
  output int                                         error_count_o,
  output int                                         pending_o
);

  typedef struct packed {
    logic [tsol_pkg::StatusWidth-1:0]     status;
    logic [tsol_pkg::EntryCountWidth-1:0] entry_count;
  } list_reply_t;

  // Shadow copy of the list, head at index 0
  logic [tsol_pkg::KeyWidth-1:0] list_keys [Capacity];
  int unsigned                   held_count;
  list_reply_t                   reply_q [$];
  int                            errors;

  assign error_count_o = errors;
  assign pending_o     = reply_q.size();

  task automatic update_list(input logic [tsol_pkg::CmdWidth-1:0] cmd,
                             input logic [tsol_pkg::KeyWidth-1:0] key,
                             output logic [tsol_pkg::StatusWidth-1:0] st);
    int unsigned                   pos;
    int unsigned                   i;
    logic [tsol_pkg::KeyWidth-1:0] held;
    pos = held_count;
    for (i = 0; i < held_count; i++) begin
      if (pos == held_count && list_keys[i] == key) pos = i;
    end
    st = tsol_pkg::ST_ABSENT;
    case (cmd)
      tsol_pkg::CMD_INSERT: begin
        if (pos < held_count) begin
          st = tsol_pkg::ST_PRESENT;
        end else if (held_count >= Capacity) begin
          st = tsol_pkg::ST_FULL;
        end else begin
          list_keys[held_count] = key;
          held_count++;
          st = tsol_pkg::ST_DONE;
        end
      end
      tsol_pkg::CMD_DELETE: begin
        if (pos < held_count) begin
          // close the gap behind the removed key
          for (i = pos; i + 1 < held_count; i++) list_keys[i] = list_keys[i+1];
          held_count--;
          st = tsol_pkg::ST_DONE;
        end
      end
      tsol_pkg::CMD_SEARCH: begin
        if (pos < held_count) begin
          if (pos > 0) begin
            held             = list_keys[pos-1];
            list_keys[pos-1] = list_keys[pos];
            list_keys[pos]   = held;
          end
          st = tsol_pkg::ST_DONE;
        end
      end
      default: st = tsol_pkg::ST_ABSENT;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_reply_t got;
    list_reply_t want;
    logic [tsol_pkg::StatusWidth-1:0] st;
    if (!rst_ni) begin
      held_count = 0;
      errors     = 0;
      reply_q.delete();
    end else begin
      // check the word shown this cycle before taking a new command
      if (done_i) begin
        got.status      = status_i;
        got.entry_count = entry_count_i;
        if (reply_q.size() == 0) begin
          $error("unexpected result word: status %0d entry_count %0d",
                 got.status, got.entry_count);
          errors++;
        end else begin
          want = reply_q.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d",
                   want.entry_count, got.entry_count);
            errors++;
          end
        end
      end
      if (start_i && !busy_i) begin
        update_list(command_i, key_i, st);
        want.status      = st;
        want.entry_count = held_count[tsol_pkg::EntryCountWidth-1:0];
        reply_q.push_back(want);
      end
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned Capacity    = 16;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PhaseItems  = 92;
  localparam int unsigned PhaseCount  = 8;
  localparam int unsigned PoolSize    = 24;
  // no command is assigned to this code
  localparam logic [tsol_pkg::CmdWidth-1:0] CmdUnused = 2'd3;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 start = 1'b0;
  logic                                 busy;
  logic [tsol_pkg::CmdWidth-1:0]        command_i = tsol_pkg::CMD_INSERT;
  logic signed [tsol_pkg::KeyWidth-1:0] key_i = '0;
  logic                                 done_o;
  logic [tsol_pkg::StatusWidth-1:0]     status_o;
  logic [tsol_pkg::EntryCountWidth-1:0] entry_count_o;

  int          error_count;
  int          replies_due;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;
  logic [tsol_pkg::KeyWidth-1:0] key_pool [PoolSize];

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  transpose_self_organizing_list #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .key_i        (key_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o)
  );

  list_checker #(
    .Capacity(Capacity)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .command_i    (command_i),
    .key_i        (key_i),
    .done_i       (done_o),
    .status_i     (status_o),
    .entry_count_i(entry_count_o),
    .error_count_o(error_count),
    .pending_o    (replies_due)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Present one word, with an optional idle gap first; return at the accepting edge.
  task automatic send_word(input logic [tsol_pkg::CmdWidth-1:0] cmd,
                           input logic [tsol_pkg::KeyWidth-1:0] key);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    command_i <= cmd;
    key_i     <= key;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    int unsigned                   r;
    logic [tsol_pkg::CmdWidth-1:0] cmd;
    logic [tsol_pkg::KeyWidth-1:0] key;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list, extremes, duplicates, transposes, deletes at head and tail
    send_word(tsol_pkg::CMD_SEARCH, 32'h0000_0000);
    send_word(tsol_pkg::CMD_DELETE, 32'h0000_0005);
    send_word(CmdUnused,            32'h0000_0000);
    send_word(tsol_pkg::CMD_INSERT, 32'h8000_0000);
    send_word(tsol_pkg::CMD_INSERT, 32'h7FFF_FFFF);
    send_word(tsol_pkg::CMD_INSERT, 32'h0000_0000);
    send_word(tsol_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    send_word(tsol_pkg::CMD_INSERT, 32'h7FFF_FFFF);
    send_word(tsol_pkg::CMD_SEARCH, 32'h8000_0000);
    send_word(tsol_pkg::CMD_SEARCH, 32'hFFFF_FFFF);
    send_word(tsol_pkg::CMD_SEARCH, 32'hFFFF_FFFF);
    send_word(tsol_pkg::CMD_SEARCH, 32'h5555_5555);
    send_word(tsol_pkg::CMD_DELETE, 32'h0000_0000);
    send_word(tsol_pkg::CMD_DELETE, 32'h8000_0000);
    send_word(tsol_pkg::CMD_SEARCH, 32'h7FFF_FFFF);
    send_word(tsol_pkg::CMD_DELETE, 32'h7FFF_FFFF);
    send_word(tsol_pkg::CMD_DELETE, 32'hFFFF_FFFF);
    send_word(tsol_pkg::CMD_DELETE, 32'hFFFF_FFFF);
    send_word(CmdUnused,            32'hFFFF_FFFF);
    send_word(tsol_pkg::CMD_INSERT, 32'hAAAA_AAAA);
    send_word(tsol_pkg::CMD_INSERT, 32'h5555_5555);
    send_word(tsol_pkg::CMD_SEARCH, 32'h5555_5555);

    // alternate filling and draining phases over a small key pool
    for (int p = 0; p < PhaseCount; p++) begin
      case (p % 4)
        1:       idle_pct = 65;
        3:       idle_pct = 18;
        default: idle_pct = 0;
      endcase
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int k = 4; k < PoolSize; k++) key_pool[k] = $urandom;
      for (int n = 0; n < PhaseItems; n++) begin
        r = $urandom_range(99);
        if (p % 2 == 0) begin
          if (r < 55)      cmd = tsol_pkg::CMD_INSERT;
          else if (r < 75) cmd = tsol_pkg::CMD_DELETE;
          else if (r < 97) cmd = tsol_pkg::CMD_SEARCH;
          else             cmd = CmdUnused;
        end else begin
          if (r < 15)      cmd = tsol_pkg::CMD_INSERT;
          else if (r < 65) cmd = tsol_pkg::CMD_DELETE;
          else if (r < 97) cmd = tsol_pkg::CMD_SEARCH;
          else             cmd = CmdUnused;
        end
        if ($urandom_range(9) == 0) key = $urandom;
        else key = key_pool[$urandom_range(PoolSize - 1)];
        send_word(cmd, key);
      end
    end

    start <= 1'b0;
    while (replies_due != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> transpose_self_organizing_list.f
rtl/core/tsol_pkg.sv
rtl/core/tsol_cell.sv
rtl/core/transpose_self_organizing_list.sv
rtl/core/tsol_checker.sv
tb/list_checker.sv
tb/tb_top.sv
